>>> hdl/lru_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_pkg: shared types and constants for the LRU page replacement block
// Field widths, configuration register map and the status group passed from
// the compare unit to the sequencer.
// ----------------------------------------------------------------------------
package lru_pkg;

  // Default number of physical frames.
  localparam int FRAME_SLOTS_DEF = 16;

  // Payload widths.
  localparam int PAGE_W       = 16;
  localparam int STAMP_W      = 32;
  localparam int FAULT_CNT_W  = 32;
  localparam int FRAME_USED_W = 4;
  localparam int FRAMES_W     = 5;

  // Reset value of the frame count register.
  localparam logic [FRAMES_W-1:0] FRAMES_RESET = 5'd3;

  // Configuration port.
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] ADDR_FRAMES_IN_USE = 2'd0;

  // Outcome flags of one scan over the frames.
  typedef struct packed {
    logic hit;    // page found in a valid frame
    logic empty;  // an empty frame was seen
  } scan_flags_t;

endpackage

>>> hdl/lru_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_in_if: page reference channel
// Valid/ready channel carrying one page number per request.
// ----------------------------------------------------------------------------
interface lru_in_if;

  logic                        valid;
  logic                        ready;
  logic [lru_pkg::PAGE_W-1:0]  page_number;

  modport source (output valid, output page_number, input ready);
  modport sink   (input valid, input page_number, output ready);
  modport mon    (input valid, input page_number, input ready);

endinterface

>>> hdl/lru_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_out_if: replacement result channel
// Valid/ready channel carrying the outcome of one page reference.
// ----------------------------------------------------------------------------
interface lru_out_if;

  logic                              valid;
  logic                              ready;
  logic                              fault;
  logic [lru_pkg::FRAME_USED_W-1:0]  frame_used;
  logic                              evicted_valid;
  logic [lru_pkg::PAGE_W-1:0]        evicted_page;
  logic [lru_pkg::FAULT_CNT_W-1:0]   fault_total;

  modport source (output valid, output fault, output frame_used, output evicted_valid,
                  output evicted_page, output fault_total, input ready);
  modport sink   (input valid, input fault, input frame_used, input evicted_valid,
                  input evicted_page, input fault_total, output ready);
  modport mon    (input valid, input fault, input frame_used, input evicted_valid,
                  input evicted_page, input fault_total, input ready);

endinterface

>>> hdl/lru_page_replacement.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_page_replacement: least recently used page replacement engine
// Looks up each page reference in a fully associative set of frames and
// refills an empty frame, or else the least recently used one, on a fault.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one page number per request; out_ch returns one result per
//   request: fault flag, frame used, evicted page and running fault count.
//   The APB-style cfg_ port, pready tied high, holds frames_in_use at byte
//   address 0; write it only while the block is idle, which is not checked.
// Timing:
//   With n active frames (frames_in_use clamped to 1..FRAME_SLOTS), the frame
//   store, a RAM with one read port, is scanned over frames 0..n-1 one frame
//   per cycle through a single compare unit, followed by an update state that
//   writes the chosen frame and registers the result. in_ch.ready rises again
//   as the result is presented; no request is taken while one is in flight.
// Reset:
//   rst_n is synchronous and active low. It empties all frames, clears the
//   reference and fault counters and sets frames_in_use to 3.
// Back-pressure:
//   The result sits in an output register. While it is not taken the block
//   still accepts and scans the next request, then holds it in the update
//   cycle until the output register is free.
// ----------------------------------------------------------------------------
module lru_page_replacement #(
  parameter int FRAME_SLOTS = lru_pkg::FRAME_SLOTS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  lru_in_if.sink                           in_ch,
  lru_out_if.source                        out_ch,
  input  logic                             cfg_psel,
  input  logic                             cfg_penable,
  input  logic                             cfg_pwrite,
  input  logic [lru_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [lru_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [lru_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                             cfg_pready
);

  localparam int IDX_W   = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int CNT_W   = $clog2(FRAME_SLOTS + 1);
  localparam int ENTRY_W = lru_pkg::PAGE_W + lru_pkg::STAMP_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_UPD  = 3'b100
  } state_t;

  state_t                           state_r, state_nxt;
  logic [lru_pkg::FRAMES_W-1:0]     frames_r;
  logic [FRAME_SLOTS-1:0]           valid_r, valid_nxt;
  logic [lru_pkg::STAMP_W-1:0]      ref_cnt_r, ref_cnt_nxt;
  logic [lru_pkg::FAULT_CNT_W-1:0]  fault_cnt_r, fault_cnt_nxt;
  logic [lru_pkg::PAGE_W-1:0]       page_r;
  logic [CNT_W-1:0]                 iss_r, iss_nxt;
  logic                             ev_vld_r;
  logic [IDX_W-1:0]                 ev_idx_r;

  logic                             out_valid_r, out_valid_nxt;
  logic                             fault_r;
  logic [lru_pkg::FRAME_USED_W-1:0] frame_used_r;
  logic                             ev_valid_r;
  logic [lru_pkg::PAGE_W-1:0]       ev_page_r;

  logic [CNT_W-1:0]                 n_act;
  logic [IDX_W-1:0]                 last_idx;
  logic                             in_acc;
  logic                             issue;
  logic                             commit;
  logic                             cfg_wr;
  logic [ENTRY_W-1:0]               rd_data;
  logic [ENTRY_W-1:0]               wr_data;
  lru_pkg::scan_flags_t             flags;
  logic [IDX_W-1:0]                 sel_idx;
  logic [lru_pkg::PAGE_W-1:0]       old_page;

  // Active frame count, clamped to 1..FRAME_SLOTS.
  always_comb begin
    if (frames_r == '0) begin
      n_act = CNT_W'(1);
    end else if (32'(frames_r) > FRAME_SLOTS) begin
      n_act = CNT_W'(FRAME_SLOTS);
    end else begin
      n_act = CNT_W'(frames_r);
    end
  end

  assign last_idx = IDX_W'(n_act - CNT_W'(1));

  // Configuration port.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                      && (cfg_paddr == lru_pkg::ADDR_FRAMES_IN_USE);
  assign cfg_prdata = (cfg_paddr == lru_pkg::ADDR_FRAMES_IN_USE)
                      ? lru_pkg::CFG_DATA_W'(frames_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_r <= lru_pkg::FRAMES_RESET;
    end else if (cfg_wr) begin
      frames_r <= cfg_pwdata[lru_pkg::FRAMES_W-1:0];
    end
  end

  // Handshake terms.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && (state_r == ST_IDLE);
  assign issue       = (state_r == ST_SCAN) && (iss_r < n_act);
  assign commit      = (state_r == ST_UPD) && (!out_valid_r || out_ch.ready);

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    iss_nxt   = iss_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          state_nxt = ST_SCAN;
          iss_nxt   = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          iss_nxt = iss_r + CNT_W'(1);
        end
        if (ev_vld_r && (ev_idx_r == last_idx)) begin
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (commit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Frame state and counters, updated once per request.
  always_comb begin
    valid_nxt     = valid_r;
    ref_cnt_nxt   = ref_cnt_r;
    fault_cnt_nxt = fault_cnt_r;
    if (commit) begin
      valid_nxt[sel_idx] = 1'b1;
      ref_cnt_nxt = (ref_cnt_r == '1) ? ref_cnt_r : ref_cnt_r + 1'b1;
      if (!flags.hit) begin
        fault_cnt_nxt = (fault_cnt_r == '1) ? fault_cnt_r : fault_cnt_r + 1'b1;
      end
    end
  end

  // Output register takes the result when it is free or being taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      valid_r     <= '0;
      ref_cnt_r   <= '0;
      fault_cnt_r <= '0;
      out_valid_r <= 1'b0;
      ev_vld_r    <= 1'b0;
      iss_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      ref_cnt_r   <= ref_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      ev_vld_r    <= issue;
      iss_r       <= iss_nxt;
    end
  end

  // Request and result payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      page_r <= in_ch.page_number;
    end
    ev_idx_r <= iss_r[IDX_W-1:0];
    if (commit) begin
      fault_r      <= !flags.hit;
      frame_used_r <= lru_pkg::FRAME_USED_W'(sel_idx);
      ev_valid_r   <= !flags.hit && !flags.empty;
      ev_page_r    <= (!flags.hit && !flags.empty) ? old_page : '0;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.fault         = fault_r;
  assign out_ch.frame_used    = frame_used_r;
  assign out_ch.evicted_valid = ev_valid_r;
  assign out_ch.evicted_page  = ev_page_r;
  assign out_ch.fault_total   = fault_cnt_r;

  // Frame store: page number and stamp of each frame.
  assign wr_data = {page_r, ref_cnt_r};

  lru_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAME_SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (commit),
    .wr_addr (sel_idx),
    .wr_data (wr_data),
    .rd_en   (issue),
    .rd_addr (iss_r[IDX_W-1:0]),
    .rd_data (rd_data)
  );

  // Shared compare unit, fed one frame per cycle.
  lru_cmp #(
    .FRAME_SLOTS (FRAME_SLOTS)
  ) u_cmp (
    .clk       (clk),
    .rst_n     (rst_n),
    .clear     (in_acc),
    .ent_vld   (ev_vld_r),
    .ent_idx   (ev_idx_r),
    .ent_valid (valid_r[ev_idx_r]),
    .ent_page  (rd_data[ENTRY_W-1:lru_pkg::STAMP_W]),
    .ent_stamp (rd_data[lru_pkg::STAMP_W-1:0]),
    .req_page  (page_r),
    .flags     (flags),
    .sel_idx   (sel_idx),
    .old_page  (old_page)
  );

endmodule

>>> hdl/lru_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/lru_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_cmp: shared frame compare unit
// Takes one frame entry per cycle and keeps the first page match, the first
// empty frame and the frame with the smallest stamp seen so far.
// ----------------------------------------------------------------------------
module lru_cmp #(
  parameter int FRAME_SLOTS = lru_pkg::FRAME_SLOTS_DEF
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           clear,
  input  logic                                           ent_vld,
  input  logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] ent_idx,
  input  logic                                           ent_valid,
  input  logic [lru_pkg::PAGE_W-1:0]                     ent_page,
  input  logic [lru_pkg::STAMP_W-1:0]                    ent_stamp,
  input  logic [lru_pkg::PAGE_W-1:0]                     req_page,
  output lru_pkg::scan_flags_t                           flags,
  output logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] sel_idx,
  output logic [lru_pkg::PAGE_W-1:0]                     old_page
);

  localparam int IDX_W = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

  logic                         hit_r, hit_nxt;
  logic                         empty_r, empty_nxt;
  logic [IDX_W-1:0]             hit_idx_r, hit_idx_nxt;
  logic [IDX_W-1:0]             empty_idx_r, empty_idx_nxt;
  logic [IDX_W-1:0]             old_idx_r, old_idx_nxt;
  logic [lru_pkg::STAMP_W-1:0]  old_stamp_r, old_stamp_nxt;
  logic [lru_pkg::PAGE_W-1:0]   old_page_r, old_page_nxt;

  // Fold the current entry into the running results.
  always_comb begin
    hit_nxt       = hit_r;
    empty_nxt     = empty_r;
    hit_idx_nxt   = hit_idx_r;
    empty_idx_nxt = empty_idx_r;
    old_idx_nxt   = old_idx_r;
    old_stamp_nxt = old_stamp_r;
    old_page_nxt  = old_page_r;
    if (clear) begin
      hit_nxt   = 1'b0;
      empty_nxt = 1'b0;
    end else if (ent_vld) begin
      if (ent_valid && (ent_page == req_page) && !hit_r) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = ent_idx;
      end
      if (!ent_valid && !empty_r) begin
        empty_nxt     = 1'b1;
        empty_idx_nxt = ent_idx;
      end
      // Strictly smaller stamp only, so a tie keeps the lower index.
      if ((ent_idx == '0) || (ent_stamp < old_stamp_r)) begin
        old_idx_nxt   = ent_idx;
        old_stamp_nxt = ent_stamp;
        old_page_nxt  = ent_page;
      end
    end
  end

  // Control flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r   <= 1'b0;
      empty_r <= 1'b0;
    end else begin
      hit_r   <= hit_nxt;
      empty_r <= empty_nxt;
    end
  end

  // Indices and the oldest entry.
  always_ff @(posedge clk) begin
    hit_idx_r   <= hit_idx_nxt;
    empty_idx_r <= empty_idx_nxt;
    old_idx_r   <= old_idx_nxt;
    old_stamp_r <= old_stamp_nxt;
    old_page_r  <= old_page_nxt;
  end

  // A hit wins, then an empty frame, then the least recently used one.
  always_comb begin
    flags.hit   = hit_r;
    flags.empty = empty_r;
    if (hit_r) begin
      sel_idx = hit_idx_r;
    end else if (empty_r) begin
      sel_idx = empty_idx_r;
    end else begin
      sel_idx = old_idx_r;
    end
  end

  assign old_page = old_page_r;

endmodule

>>> hdl/lru_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_chk: port-level checks for the LRU page replacement block
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module lru_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              out_fault,
  input logic [lru_pkg::FRAME_USED_W-1:0]  out_frame_used,
  input logic                              out_evicted_valid,
  input logic [lru_pkg::PAGE_W-1:0]        out_evicted_page,
  input logic [lru_pkg::FAULT_CNT_W-1:0]   out_fault_total
);

  // A pending result stays offered until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn before it was taken");

  // A stalled result keeps its fault total, frame used and evicted page.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_fault_total)
      && $stable(out_frame_used) && $stable(out_evicted_page))
    else $error("stalled result changed");

  // A request occupies the block: no second request on the next edge.
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while the previous one is still being scanned");

  // A hit never reports an eviction.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_fault |-> !out_evicted_valid && (out_evicted_page == '0))
    else $error("eviction reported on a hit");

endmodule

bind lru_page_replacement lru_chk u_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_fault         (out_ch.fault),
  .out_frame_used    (out_ch.frame_used),
  .out_evicted_valid (out_ch.evicted_valid),
  .out_evicted_page  (out_ch.evicted_page),
  .out_fault_total   (out_ch.fault_total)
);

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the LRU page replacement engine
// Page references are pushed from a stimulus queue by a valid/ready driver,
// each accepted request is run through an LRU predictor of the frame set, and
// every result on the output channel is compared field by field with the
// oldest prediction. The frame count is changed over the APB-style port
// between phases while the engine is idle, and read back after each write.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int SLOTS = lru_pkg::FRAME_SLOTS_DEF;
  localparam int MAX_REPORTS = 10;
  localparam int PAD_W = lru_pkg::CFG_DATA_W - lru_pkg::FRAMES_W;

  typedef struct packed {
    logic                             fault;
    logic [lru_pkg::FRAME_USED_W-1:0] frame_used;
    logic                             evicted_valid;
    logic [lru_pkg::PAGE_W-1:0]       evicted_page;
    logic [lru_pkg::FAULT_CNT_W-1:0]  fault_total;
  } lru_outcome_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_psel;
  logic                           cfg_penable;
  logic                           cfg_pwrite;
  logic [lru_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [lru_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [lru_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                           cfg_pready;

  lru_in_if  ref_ch ();
  lru_out_if res_ch ();

  lru_page_replacement u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (ref_ch),
    .out_ch      (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Stimulus and prediction stores.
  logic [lru_pkg::PAGE_W-1:0] pending_pages [$];
  lru_outcome_t               predicted_outcomes [$];

  // Predictor copy of the frame set and the frame count register.
  logic [lru_pkg::PAGE_W-1:0]      slot_page  [SLOTS];
  bit                              slot_valid [SLOTS];
  logic [lru_pkg::STAMP_W-1:0]     slot_stamp [SLOTS];
  logic [lru_pkg::STAMP_W-1:0]     ref_count;
  logic [lru_pkg::FAULT_CNT_W-1:0] fault_count;
  logic [lru_pkg::FRAMES_W-1:0]    frames_setting;

  int error_count;
  bit page_taken;
  bit quiet;
  bit hold_request;
  bit hold_done;
  int hold_left;
  int send_gap;
  int sink_gap;

  // Clock, 12 ns period.
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Apply one page reference to the predicted frame set.
  function automatic lru_outcome_t lru_lookup(input logic [lru_pkg::PAGE_W-1:0] page);
    int                          n;
    int                          hit_idx;
    int                          victim;
    logic [lru_pkg::STAMP_W-1:0] oldest;
    lru_outcome_t                r;
    r = '0;
    n = int'(frames_setting);
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    hit_idx = -1;
    for (int j = 0; j < n; j++) begin
      if (hit_idx < 0 && slot_valid[j] && slot_page[j] == page) hit_idx = j;
    end
    if (hit_idx >= 0) begin
      slot_stamp[hit_idx] = ref_count;
      r.frame_used = hit_idx[lru_pkg::FRAME_USED_W-1:0];
    end else begin
      victim = -1;
      for (int j = 0; j < n; j++) begin
        if (victim < 0 && !slot_valid[j]) victim = j;
      end
      if (victim < 0) begin
        // No empty frame: the smallest stamp goes, lowest index on a tie.
        victim = 0;
        oldest = slot_stamp[0];
        for (int j = 1; j < n; j++) begin
          if (slot_stamp[j] < oldest) begin
            oldest = slot_stamp[j];
            victim = j;
          end
        end
        r.evicted_valid = 1'b1;
        r.evicted_page  = slot_page[victim];
      end
      slot_page[victim]  = page;
      slot_valid[victim] = 1'b1;
      slot_stamp[victim] = ref_count;
      if (fault_count != '1) fault_count = fault_count + 1'b1;
      r.fault      = 1'b1;
      r.frame_used = victim[lru_pkg::FRAME_USED_W-1:0];
    end
    if (ref_count != '1) ref_count = ref_count + 1'b1;
    r.fault_total = fault_count;
    return r;
  endfunction

  task automatic report_error(input string what, input logic [31:0] want,
                              input logic [31:0] seen);
    if (error_count < MAX_REPORTS)
      $display("%0t: %s mismatch: expected %0h, got %0h", $time, what, want, seen);
    error_count++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] want,
                               input logic [31:0] seen);
    if (seen !== want) report_error(what, want, seen);
  endtask

  // Wait until every queued request has been taken and every result returned.
  task automatic wait_drained();
    while (pending_pages.size() != 0 || predicted_outcomes.size() != 0)
      @(posedge clk);
  endtask

  task automatic check_frames_readback(input logic [lru_pkg::FRAMES_W-1:0] want);
    @(negedge clk);
    cfg_psel   = 1'b1;
    cfg_pwrite = 1'b0;
    cfg_paddr  = lru_pkg::ADDR_FRAMES_IN_USE;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    compare_field("frames_in_use readback", 32'(want),
                  32'(cfg_prdata[lru_pkg::FRAMES_W-1:0]));
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Write the frame count once the engine has gone idle, then read it back.
  task automatic write_frames(input logic [lru_pkg::FRAMES_W-1:0] value);
    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_pwrite  = 1'b1;
    cfg_penable = 1'b0;
    cfg_paddr   = lru_pkg::ADDR_FRAMES_IN_USE;
    cfg_pwdata  = {PAD_W'($urandom_range(0, 2 ** PAD_W - 1)), value};
    @(negedge clk);
    cfg_penable = 1'b1;
    @(negedge clk);
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    frames_setting = value;
    check_frames_readback(value);
  endtask

  // One phase of random references, mostly drawn from a small working set
  // so that hits and evictions dominate, the rest spread over the page range.
  task automatic random_phase(input logic [lru_pkg::FRAMES_W-1:0] value, input int count);
    logic [lru_pkg::PAGE_W-1:0] pool [24];
    int                         n;
    int                         pool_len;
    write_frames(value);
    n = int'(value);
    if (n < 1) n = 1;
    if (n > SLOTS) n = SLOTS;
    pool_len = n + int'($urandom_range(0, 6));
    if (pool_len > 24) pool_len = 24;
    for (int i = 0; i < pool_len; i++) pool[i] = lru_pkg::PAGE_W'($urandom_range(0, 65535));
    repeat (count) begin
      if ($urandom_range(0, 9) < 8)
        pending_pages.push_back(pool[$urandom_range(0, pool_len - 1)]);
      else
        pending_pages.push_back(lru_pkg::PAGE_W'($urandom_range(0, 65535)));
    end
  endtask

  // Request driver: holds a request until it is taken, idles in bursts.
  always @(negedge clk) begin
    if (rst_n) begin
      if (ref_ch.valid && !page_taken) begin
        ref_ch.valid <= 1'b1;
      end else if (send_gap > 0) begin
        ref_ch.valid <= 1'b0;
        send_gap     <= send_gap - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        ref_ch.valid <= 1'b0;
        send_gap     <= $urandom_range(0, 11);
      end else if (pending_pages.size() != 0) begin
        ref_ch.valid       <= 1'b1;
        ref_ch.page_number <= pending_pages[0];
      end else begin
        ref_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here and obeyed by the result sink.
  always @(negedge clk) begin
    if (hold_request && !hold_done) begin
      hold_left <= 250;
      hold_done <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Result sink: stalls in random bursts and during the long hold-off.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        res_ch.ready <= 1'b0;
        sink_gap     <= sink_gap - 1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        sink_gap     <= $urandom_range(0, 11);
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  // Monitor: check returned results, then predict for the request taken.
  always @(posedge clk) begin
    lru_outcome_t want;
    page_taken = 1'b0;
    if (rst_n) begin
      if (res_ch.valid && res_ch.ready) begin
        if (predicted_outcomes.size() == 0) begin
          if (error_count < MAX_REPORTS)
            $display("%0t: result returned with no request outstanding", $time);
          error_count++;
        end else begin
          want = predicted_outcomes.pop_front();
          compare_field("fault", 32'(want.fault), 32'(res_ch.fault));
          compare_field("frame_used", 32'(want.frame_used), 32'(res_ch.frame_used));
          compare_field("evicted_valid", 32'(want.evicted_valid),
                        32'(res_ch.evicted_valid));
          compare_field("evicted_page", 32'(want.evicted_page), 32'(res_ch.evicted_page));
          compare_field("fault_total", want.fault_total, res_ch.fault_total);
        end
      end
      if (ref_ch.valid && ref_ch.ready) begin
        page_taken = 1'b1;
        predicted_outcomes.push_back(lru_lookup(ref_ch.page_number));
        void'(pending_pages.pop_front());
      end
    end
  end

  // Overall time limit.
  initial begin
    #4_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Reset, directed references, random phases and the final check.
  initial begin
    logic [lru_pkg::FRAMES_W-1:0] settings [12];
    rst_n        = 1'b0;
    cfg_psel     = 1'b0;
    cfg_penable  = 1'b0;
    cfg_pwrite   = 1'b0;
    cfg_paddr    = '0;
    cfg_pwdata   = '0;
    ref_ch.valid = 1'b0;
    ref_ch.page_number = '0;
    res_ch.ready = 1'b0;
    error_count  = 0;
    page_taken   = 1'b0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    hold_done    = 1'b0;
    hold_left    = 0;
    send_gap     = 0;
    sink_gap     = 0;
    ref_count    = '0;
    fault_count  = '0;
    frames_setting = lru_pkg::FRAMES_RESET;
    for (int i = 0; i < SLOTS; i++) begin
      slot_valid[i] = 1'b0;
      slot_stamp[i] = '0;
    end
    settings = '{5'd16, 5'd4, 5'd1, 5'd0, 5'd31, 5'd8, 5'd17, 5'd2, 5'd12,
                 5'd16, 5'd5, 5'd3};
    settings[9] = lru_pkg::FRAMES_W'($urandom_range(0, 31));

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    check_frames_readback(lru_pkg::FRAMES_RESET);

    // Reset frame count: fill empties, hit, then evict the least recent.
    pending_pages.push_back(16'h0000);
    pending_pages.push_back(16'hFFFF);
    pending_pages.push_back(16'h0000);
    pending_pages.push_back(16'h00A5);
    pending_pages.push_back(16'h5A00);
    pending_pages.push_back(16'hFFFF);
    pending_pages.push_back(16'h00A5);

    // A single frame: every new page evicts the last.
    write_frames(5'd1);
    pending_pages.push_back(16'h1234);
    pending_pages.push_back(16'h1234);

    // Zero frames behave as one.
    write_frames(5'd0);
    pending_pages.push_back(16'hABCD);

    // Growing again: frames beyond the old count hit on what they kept.
    write_frames(5'd16);
    pending_pages.push_back(16'h5A00);
    pending_pages.push_back(16'h00A5);
    pending_pages.push_back(16'h0001);
    pending_pages.push_back(16'h0002);

    // A count above the slot total behaves as the slot total.
    write_frames(5'd31);
    pending_pages.push_back(16'hABCD);
    pending_pages.push_back(16'h8000);

    // Shrinking hides upper frames; growing past the total brings them back.
    write_frames(5'd2);
    pending_pages.push_back(16'h0001);
    write_frames(5'd17);
    pending_pages.push_back(16'h0001);
    pending_pages.push_back(16'h0002);

    // Random phases over a range of frame counts.
    for (int p = 0; p < 12; p++) begin
      if (p == 2) hold_request = 1'b1;
      if (p == 10) quiet = 1'b1;
      random_phase(settings[p], 56);
      // Let the sender pause until every result of this phase is back.
      if (p == 5) wait_drained();
    end

    wait_drained();
    repeat (SLOTS + 8) @(posedge clk);
    if (error_count == 0 && predicted_outcomes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
